// ----- hw/rtl/bmn_pkg.sv -----
// ----------------------------------------------------------------------------
// bmn_pkg
// Shared codes for the button menu navigator: event kinds, button masks,
// overlay states, action codes, tab codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bmn_pkg;

    // event kind carried with each input transaction
    typedef enum logic [1:0] {
        OP_BUTTON = 2'd0,
        OP_ERROR  = 2'd1,
        OP_REOPEN = 2'd2
    } t_op;

    // single-button masks
    localparam logic [5:0] BTN_CENTER = 6'h01;
    localparam logic [5:0] BTN_LEFT   = 6'h02;
    localparam logic [5:0] BTN_RIGHT  = 6'h04;
    localparam logic [5:0] BTN_UP     = 6'h08;
    localparam logic [5:0] BTN_DOWN   = 6'h10;
    localparam logic [5:0] BTN_BACK   = 6'h20;

    // overlay states
    localparam logic [2:0] OV_NONE   = 3'd0;
    localparam logic [2:0] OV_NOPROG = 3'd1;
    localparam logic [2:0] OV_SOON   = 3'd2;
    localparam logic [2:0] OV_SD_YES = 3'd3;
    localparam logic [2:0] OV_SD_NO  = 3'd4;

    // action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_OFF  = 2'd1;
    localparam logic [1:0] ACT_SET  = 2'd2;
    localparam logic [1:0] ACT_RUN  = 2'd3;

    // tabs
    localparam logic [1:0] TAB_PROG = 2'd0;
    localparam logic [1:0] TAB_APPS = 2'd1;
    localparam logic [1:0] TAB_SETT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PROG_COUNT = 2'd0;
    localparam logic [1:0] CFG_APP_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SETT_COUNT = 2'd2;

endpackage

// ----- hw/rtl/button_menu_navigator.sv -----
// ----------------------------------------------------------------------------
// button_menu_navigator
// Front-panel menu controller: tab, per-tab selection and overlay dialog
// state, updated by button, error and reopen events.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one result transaction. An event
// is captured in an input register; from that register the menu state and
// the result register are updated together from a single layer of compare
// and increment logic, so the block takes one event per clock while the
// master side accepts results; the input register and the result register
// let a new event enter while a finished result waits on a stalled master
// side. Entry counts above the smaller of MAX_ENTRIES and 16 are clamped to
// that limit. The configuration channel is always ready and should only be
// written while no event is in flight.
module button_menu_navigator
    import bmn_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] buttons, [7:6] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] slot, [5:4] active_tab,
                                        // [9:6] active_entry, [12:10] overlay_kind,
                                        // [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] action
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int          LIM_INT   = (MAX_ENTRIES > 16) ? 16 : MAX_ENTRIES;
    localparam logic [4:0]  ENTRY_LIM = 5'(LIM_INT);

    // configuration registers
    logic [4:0] r_prog_count, r_app_count, r_sett_count;

    // input stage
    logic       r_in_vld;
    logic [1:0] r_in_op;
    logic [5:0] r_in_btn;

    // menu state
    logic [1:0] r_tab, n_tab;
    logic [3:0] r_entry [3];
    logic [3:0] n_entry [3];
    logic [2:0] r_overlay, n_overlay;

    // result stage
    logic       r_out_vld;
    logic [1:0] r_action, n_action;
    logic [3:0] r_slot, n_slot;
    logic [1:0] r_res_tab;
    logic [3:0] r_res_entry, n_res_entry;
    logic [2:0] r_res_overlay;

    logic       advance;
    logic [4:0] raw_count, tab_count;
    logic [3:0] cur_sel, new_sel;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_count <= 5'd4;
            r_app_count  <= 5'd2;
            r_sett_count <= 5'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROG_COUNT: r_prog_count <= i_cfg_data;
                CFG_APP_COUNT:  r_app_count  <= i_cfg_data;
                CFG_SETT_COUNT: r_sett_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op  <= s_axis_tuser;
            r_in_btn <= s_axis_tdata[5:0];
        end
    end

    // entry count of the current tab, clamped
    always_comb begin
        case (r_tab)
            TAB_PROG: raw_count = r_prog_count;
            TAB_APPS: raw_count = r_app_count;
            TAB_SETT: raw_count = r_sett_count;
            default:  raw_count = 5'd0;
        endcase
        tab_count = (raw_count > ENTRY_LIM) ? ENTRY_LIM : raw_count;
        cur_sel   = (r_tab <= TAB_SETT) ? r_entry[r_tab] : 4'd0;
        if (r_in_btn == BTN_DOWN) begin
            new_sel = (({1'b0, cur_sel} + 5'd1) < tab_count) ? cur_sel + 4'd1 : cur_sel;
        end else begin
            new_sel = (cur_sel != 4'd0) ? cur_sel - 4'd1 : cur_sel;
        end
    end

    // next state and result for the event in the input register
    always_comb begin
        n_tab     = r_tab;
        n_entry   = r_entry;
        n_overlay = r_overlay;
        n_action  = ACT_NONE;
        n_slot    = 4'd0;

        if (r_in_op == OP_ERROR) begin
            n_overlay = OV_NOPROG;
        end else if (r_in_op == OP_REOPEN) begin
            n_overlay = OV_NONE;
        end else if (r_in_op == OP_BUTTON) begin
            case (r_overlay)
                OV_NOPROG, OV_SOON: begin
                    if (r_in_btn == BTN_CENTER || r_in_btn == BTN_BACK) n_overlay = OV_NONE;
                end
                OV_SD_YES: begin
                    if (r_in_btn == BTN_CENTER) n_action = ACT_OFF;
                    if (r_in_btn == BTN_LEFT)   n_overlay = OV_SD_NO;
                    if (r_in_btn == BTN_BACK)   n_overlay = OV_NONE;
                end
                OV_SD_NO: begin
                    if (r_in_btn == BTN_CENTER || r_in_btn == BTN_BACK) n_overlay = OV_NONE;
                    if (r_in_btn == BTN_RIGHT) n_overlay = OV_SD_YES;
                end
                default: begin
                    // no dialog open: normal navigation
                    if (r_in_btn == BTN_BACK) begin
                        n_overlay = OV_SD_NO;
                    end else if (r_in_btn == BTN_LEFT && r_tab != TAB_PROG) begin
                        n_tab = r_tab - 2'd1;
                    end else if (r_in_btn == BTN_RIGHT && r_tab < TAB_SETT) begin
                        n_tab = r_tab + 2'd1;
                    end else if (r_tab <= TAB_SETT) begin
                        if (r_in_btn == BTN_DOWN || r_in_btn == BTN_UP) begin
                            n_entry[r_tab] = new_sel;
                            if (r_tab == TAB_PROG) begin
                                n_action = ACT_SET;
                                n_slot   = new_sel;
                            end
                        end else if (r_in_btn == BTN_CENTER) begin
                            if (r_tab == TAB_PROG) begin
                                n_action = ACT_RUN;
                                n_slot   = r_entry[0];
                            end else if (r_tab == TAB_APPS) begin
                                n_overlay = OV_SOON;
                            end
                        end
                    end
                end
            endcase
        end

        n_res_entry = (n_tab <= TAB_SETT) ? n_entry[n_tab] : 4'd0;
    end

    // menu state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab     <= TAB_PROG;
            r_entry   <= '{default: 4'd0};
            r_overlay <= OV_NONE;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_tab     <= n_tab;
                r_entry   <= n_entry;
                r_overlay <= n_overlay;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (advance) begin
            r_action      <= n_action;
            r_slot        <= n_slot;
            r_res_tab     <= n_tab;
            r_res_entry   <= n_res_entry;
            r_res_overlay <= n_overlay;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_action;
    assign m_axis_tdata  = {3'b000, r_res_overlay, r_res_entry, r_res_tab, r_slot};

endmodule

// ----- hw/rtl/bmn_checker.sv -----
// ----------------------------------------------------------------------------
// bmn_checker
// Port-level checks for the button menu navigator, bound to the top level.
// ----------------------------------------------------------------------------
module bmn_checker
    import bmn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only three tabs and five overlay states exist
    a_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:4] != 2'd3 && m_axis_tdata[12:10] <= OV_SD_NO)
        else $error("view fields out of range");

    // set and run refer to the programs tab selection
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_SET || m_axis_tuser == ACT_RUN) |->
            m_axis_tdata[5:4] == TAB_PROG && m_axis_tdata[3:0] == m_axis_tdata[9:6])
        else $error("slot does not match programs selection");

    // shutdown only comes from the dialog with yes highlighted
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_OFF |-> m_axis_tdata[12:10] == OV_SD_YES)
        else $error("shutdown without confirmation");

    // slot is zero unless a set or run action carries it
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_NONE || m_axis_tuser == ACT_OFF) |->
            m_axis_tdata[3:0] == 4'd0)
        else $error("slot set without set or run action");

endmodule

bind button_menu_navigator bmn_checker u_bmn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
